@@ hw/rtl/ubl_pkg.sv @@
// ubl_pkg: shared types and codes for the byte-level usart model
// word layouts for both channels, operation and phase codes, mode and command fields
// no dependencies
package ubl_pkg;

    typedef struct packed {
        logic [2:0] operation;
        logic       address_bit;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
        logic [7:0] tick_count;
        logic       dsr_n;
    } ubl_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       txrdy_pin;
        logic       rxrdy_pin;
        logic       txe_pin;
        logic       dtr_pin;
        logic       rts_pin;
        logic       syndet_pin;
    } ubl_result_t;

    typedef enum logic [1:0] {
        PH_MODE,
        PH_SYNC,
        PH_CMD
    } phase_t;

    localparam logic [2:0] OP_BUS_READ  = 3'd0;
    localparam logic [2:0] OP_BUS_WRITE = 3'd1;
    localparam logic [2:0] OP_RX_BYTE   = 3'd2;
    localparam logic [2:0] OP_SYS_TICK  = 3'd3;
    localparam logic [2:0] OP_TXC_RISE  = 3'd4;
    localparam logic [2:0] OP_C_RISE    = 3'd5;
    localparam logic [2:0] OP_DSR       = 3'd6;

    localparam logic [1:0] BAUD_SYNC = 2'd0;
    localparam logic [1:0] BAUD_X1   = 2'd1;
    localparam logic [1:0] BAUD_X16  = 2'd2;
    localparam logic [1:0] BAUD_X64  = 2'd3;

    localparam logic [1:0] STOP_TWO = 2'd3;

    localparam int CMD_TX_ENABLE = 0;
    localparam int CMD_DTR       = 1;
    localparam int CMD_RX_ENABLE = 2;
    localparam int CMD_ERR_RESET = 4;
    localparam int CMD_RTS       = 5;
    localparam int CMD_INT_RESET = 6;
    localparam int CMD_HUNT      = 7;

    localparam int SHIFT_W    = 11;
    localparam int CHAR_CLK_W = 10;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 11'd2047;

endpackage

@@ hw/rtl/ubl_in_if.sv @@
// ubl_in_if: valid/ready channel carrying one input word
// depends on ubl_pkg
interface ubl_in_if;
    import ubl_pkg::*;

    logic      valid;
    logic      ready;
    ubl_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

@@ hw/rtl/ubl_out_if.sv @@
// ubl_out_if: valid/ready channel carrying one result word
// depends on ubl_pkg
interface ubl_out_if;
    import ubl_pkg::*;

    logic        valid;
    logic        ready;
    ubl_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

@@ hw/rtl/ubl_core.sv @@
// ubl_core: usart state registers and the single-pass update for one input word
// depends on ubl_pkg
module ubl_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  ubl_pkg::ubl_item_t   item,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    output ubl_pkg::ubl_result_t result
);
    import ubl_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [1:0]            sync_left_reg, sync_left_next;
    logic [7:0]            sync_pat0_reg, sync_pat0_next;
    logic [7:0]            sync_pat1_reg, sync_pat1_next;
    logic                  synchronous_reg, synchronous_next;
    logic                  one_sync_reg, one_sync_next;
    logic [CHAR_CLK_W-1:0] char_clocks_reg, char_clocks_next;
    logic                  st_txrdy_reg, st_txrdy_next;
    logic                  st_rxrdy_reg, st_rxrdy_next;
    logic                  st_txe_reg, st_txe_next;
    logic                  st_overrun_reg, st_overrun_next;
    logic                  st_dsr_reg, st_dsr_next;
    logic                  syndet_reg, syndet_next;
    logic [7:0]            tx_hold_reg, tx_hold_next;
    logic [7:0]            rx_hold_reg, rx_hold_next;
    logic                  tx_full_reg, tx_full_next;
    logic                  rx_full_reg, rx_full_next;
    logic                  tx_on_reg, tx_on_next;
    logic                  rx_on_reg, rx_on_next;
    logic                  hunting_reg, hunting_next;
    logic                  first_sync_reg, first_sync_next;
    logic                  clk_ext_reg, clk_ext_next;
    logic [SHIFT_W-1:0]    shift_count_reg, shift_count_next;
    logic                  dtr_reg, dtr_next;
    logic                  rts_reg, rts_next;

    logic [3:0]            mode_bits;
    logic [3:0]            async_bits;
    logic                  count_en;
    logic [7:0]            count_n;
    logic [SHIFT_W:0]      count_sum;
    logic [SHIFT_W-1:0]    count_sat;
    logic [SHIFT_W-1:0]    txc_inc;
    logic                  sync_idx;
    logic [1:0]            sync_total;
    logic [7:0]            wd;
    logic                  do_refresh;
    logic                  read_status;
    logic                  sent;

    assign wd         = item.write_data;
    assign mode_bits  = 4'd5 + {2'b00, wd[3:2]} + {3'b000, wd[4]};
    assign async_bits = mode_bits + 4'd1 + ((wd[7:6] == STOP_TWO) ? 4'd2 : 4'd1);
    assign sync_total = one_sync_reg ? 2'd1 : 2'd2;
    assign sync_idx   = sync_total[0] ^ sync_left_reg[0];
    assign count_sum  = {1'b0, shift_count_reg} + {{(SHIFT_W-7){1'b0}}, count_n};
    assign count_sat  = (count_sum > {1'b0, SHIFT_MAX}) ? SHIFT_MAX : count_sum[SHIFT_W-1:0];
    assign txc_inc    = shift_count_reg + 11'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        sync_left_next   = sync_left_reg;
        sync_pat0_next   = sync_pat0_reg;
        sync_pat1_next   = sync_pat1_reg;
        synchronous_next = synchronous_reg;
        one_sync_next    = one_sync_reg;
        char_clocks_next = char_clocks_reg;
        st_txrdy_next    = st_txrdy_reg;
        st_rxrdy_next    = st_rxrdy_reg;
        st_txe_next      = st_txe_reg;
        st_overrun_next  = st_overrun_reg;
        st_dsr_next      = st_dsr_reg;
        syndet_next      = syndet_reg;
        tx_hold_next     = tx_hold_reg;
        rx_hold_next     = rx_hold_reg;
        tx_full_next     = tx_full_reg;
        rx_full_next     = rx_full_reg;
        tx_on_next       = tx_on_reg;
        rx_on_next       = rx_on_reg;
        hunting_next     = hunting_reg;
        first_sync_next  = first_sync_reg;
        clk_ext_next     = clk_ext_reg | (cfg_we & cfg_wdata);
        shift_count_next = shift_count_reg;
        dtr_next         = dtr_reg;
        rts_next         = rts_reg;
        do_refresh       = 1'b0;
        read_status      = 1'b0;
        sent             = 1'b0;
        count_en         = 1'b0;
        count_n          = 8'd1;
        result           = '0;

        if (accept)
        begin
            unique case (item.operation)
                OP_BUS_READ:
                begin
                    do_refresh = 1'b1;
                    if (!item.address_bit)
                    begin
                        rx_full_next     = 1'b0;
                        result.read_data = rx_hold_reg;
                    end
                    else
                    begin
                        read_status = 1'b1;
                    end
                end
                OP_BUS_WRITE:
                begin
                    if (!item.address_bit)
                    begin
                        tx_hold_next = wd;
                        tx_full_next = 1'b1;
                        do_refresh   = 1'b1;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_MODE:
                            begin
                                if (wd[1:0] == BAUD_SYNC)
                                begin
                                    synchronous_next = 1'b1;
                                    one_sync_next    = wd[7];
                                    char_clocks_next = {6'b0, mode_bits};
                                    sync_left_next   = wd[7] ? 2'd1 : 2'd2;
                                    phase_next       = PH_SYNC;
                                end
                                else
                                begin
                                    synchronous_next = 1'b0;
                                    unique case (wd[1:0])
                                        BAUD_X16: char_clocks_next = {2'b0, async_bits, 4'b0};
                                        BAUD_X64: char_clocks_next = {async_bits, 6'b0};
                                        default:  char_clocks_next = {6'b0, async_bits};
                                    endcase
                                    phase_next = PH_CMD;
                                end
                            end
                            PH_SYNC:
                            begin
                                if (sync_idx)
                                    sync_pat1_next = wd;
                                else
                                    sync_pat0_next = wd;
                                sync_left_next = sync_left_reg - 2'd1;
                                if (sync_left_next == 2'd0)
                                    phase_next = PH_CMD;
                            end
                            PH_CMD:
                            begin
                                if (wd[CMD_INT_RESET])
                                begin
                                    // internal reset: all but the external clock mark
                                    phase_next       = PH_MODE;
                                    sync_left_next   = 2'd0;
                                    sync_pat0_next   = 8'd0;
                                    sync_pat1_next   = 8'd0;
                                    synchronous_next = 1'b0;
                                    one_sync_next    = 1'b0;
                                    char_clocks_next = 10'd1;
                                    st_txrdy_next    = 1'b0;
                                    st_rxrdy_next    = 1'b0;
                                    st_txe_next      = 1'b1;
                                    st_overrun_next  = 1'b0;
                                    st_dsr_next      = 1'b0;
                                    syndet_next      = 1'b0;
                                    tx_hold_next     = 8'd0;
                                    rx_hold_next     = 8'd0;
                                    tx_full_next     = 1'b0;
                                    rx_full_next     = 1'b0;
                                    tx_on_next       = 1'b0;
                                    rx_on_next       = 1'b0;
                                    hunting_next     = 1'b0;
                                    first_sync_next  = 1'b0;
                                    shift_count_next = '0;
                                    dtr_next         = 1'b0;
                                    rts_next         = 1'b0;
                                end
                                else
                                begin
                                    tx_on_next = wd[CMD_TX_ENABLE];
                                    rx_on_next = wd[CMD_RX_ENABLE];
                                    dtr_next   = wd[CMD_DTR];
                                    rts_next   = wd[CMD_RTS];
                                    if (wd[CMD_ERR_RESET])
                                        st_overrun_next = 1'b0;
                                    if (wd[CMD_HUNT] && synchronous_reg)
                                    begin
                                        hunting_next    = 1'b1;
                                        first_sync_next = 1'b0;
                                        syndet_next     = 1'b0;
                                    end
                                    do_refresh = 1'b1;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
                OP_RX_BYTE:
                begin
                    if (rx_on_reg)
                    begin
                        if (synchronous_reg && hunting_reg)
                        begin
                            if (item.rx_byte == sync_pat0_reg)
                            begin
                                if (one_sync_reg || first_sync_reg)
                                begin
                                    hunting_next    = 1'b0;
                                    first_sync_next = 1'b0;
                                    syndet_next     = 1'b1;
                                end
                                else
                                begin
                                    first_sync_next = 1'b1;
                                end
                            end
                            else if (!one_sync_reg && first_sync_reg
                                     && item.rx_byte == sync_pat1_reg)
                            begin
                                hunting_next    = 1'b0;
                                first_sync_next = 1'b0;
                                syndet_next     = 1'b1;
                            end
                            else
                            begin
                                first_sync_next = 1'b0;
                            end
                        end
                        else
                        begin
                            if (rx_full_reg)
                                st_overrun_next = 1'b1;
                            rx_hold_next = item.rx_byte;
                            rx_full_next = 1'b1;
                            do_refresh   = 1'b1;
                        end
                    end
                end
                OP_SYS_TICK:
                begin
                    count_en = !clk_ext_reg;
                    count_n  = item.tick_count;
                end
                OP_TXC_RISE:
                begin
                    if (tx_on_reg && tx_full_reg)
                    begin
                        if (txc_inc >= {1'b0, char_clocks_reg})
                        begin
                            shift_count_next = '0;
                            sent             = 1'b1;
                        end
                        else
                        begin
                            shift_count_next = txc_inc;
                        end
                    end
                end
                OP_C_RISE:
                begin
                    clk_ext_next = 1'b1;
                    count_en     = 1'b1;
                end
                OP_DSR:
                begin
                    do_refresh = 1'b1;
                end
                default:
                begin
                    do_refresh = 1'b0;
                end
            endcase

            if (count_en && tx_on_reg && tx_full_reg)
            begin
                if (count_sat >= {1'b0, char_clocks_reg})
                begin
                    shift_count_next = count_sat - {1'b0, char_clocks_reg};
                    sent             = 1'b1;
                end
                else
                begin
                    shift_count_next = count_sat;
                end
            end

            if (sent)
            begin
                tx_full_next   = 1'b0;
                do_refresh     = 1'b1;
                result.tx_valid = 1'b1;
                result.tx_byte  = tx_hold_reg;
            end

            if (do_refresh)
            begin
                st_txrdy_next = tx_on_next && !tx_full_next;
                st_txe_next   = !tx_full_next;
                st_rxrdy_next = rx_full_next;
                st_dsr_next   = !item.dsr_n;
            end

            if (read_status)
            begin
                result.read_data = {st_dsr_next, syndet_reg, 1'b0, st_overrun_next, 1'b0,
                                    st_txe_next, st_rxrdy_next, st_txrdy_next};
                syndet_next = 1'b0;
            end
        end

        result.txrdy_pin  = st_txrdy_next;
        result.rxrdy_pin  = st_rxrdy_next;
        result.txe_pin    = st_txe_next;
        result.dtr_pin    = dtr_next;
        result.rts_pin    = rts_next;
        result.syndet_pin = syndet_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_MODE;
            sync_left_reg   <= 2'd0;
            sync_pat0_reg   <= 8'd0;
            sync_pat1_reg   <= 8'd0;
            synchronous_reg <= 1'b0;
            one_sync_reg    <= 1'b0;
            char_clocks_reg <= 10'd1;
            st_txrdy_reg    <= 1'b0;
            st_rxrdy_reg    <= 1'b0;
            st_txe_reg      <= 1'b1;
            st_overrun_reg  <= 1'b0;
            st_dsr_reg      <= 1'b0;
            syndet_reg      <= 1'b0;
            tx_hold_reg     <= 8'd0;
            rx_hold_reg     <= 8'd0;
            tx_full_reg     <= 1'b0;
            rx_full_reg     <= 1'b0;
            tx_on_reg       <= 1'b0;
            rx_on_reg       <= 1'b0;
            hunting_reg     <= 1'b0;
            first_sync_reg  <= 1'b0;
            clk_ext_reg     <= 1'b0;
            shift_count_reg <= '0;
            dtr_reg         <= 1'b0;
            rts_reg         <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            sync_left_reg   <= sync_left_next;
            sync_pat0_reg   <= sync_pat0_next;
            sync_pat1_reg   <= sync_pat1_next;
            synchronous_reg <= synchronous_next;
            one_sync_reg    <= one_sync_next;
            char_clocks_reg <= char_clocks_next;
            st_txrdy_reg    <= st_txrdy_next;
            st_rxrdy_reg    <= st_rxrdy_next;
            st_txe_reg      <= st_txe_next;
            st_overrun_reg  <= st_overrun_next;
            st_dsr_reg      <= st_dsr_next;
            syndet_reg      <= syndet_next;
            tx_hold_reg     <= tx_hold_next;
            rx_hold_reg     <= rx_hold_next;
            tx_full_reg     <= tx_full_next;
            rx_full_reg     <= rx_full_next;
            tx_on_reg       <= tx_on_next;
            rx_on_reg       <= rx_on_next;
            hunting_reg     <= hunting_next;
            first_sync_reg  <= first_sync_next;
            clk_ext_reg     <= clk_ext_next;
            shift_count_reg <= shift_count_next;
            dtr_reg         <= dtr_next;
            rts_reg         <= rts_next;
        end
    end

endmodule

@@ hw/rtl/ubl_out_buf.sv @@
// ubl_out_buf: two-entry result buffer, output register plus skid entry
// depends on ubl_pkg and ubl_out_if
module ubl_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ubl_pkg::ubl_result_t push_data,
    output logic                 can_push,
    ubl_out_if.source            result
);
    import ubl_pkg::*;

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    ubl_result_t main_data_reg, main_data_next;
    ubl_result_t skid_data_reg, skid_data_next;
    logic        pop;

    assign pop          = main_valid_reg & result.ready;
    assign can_push     = !skid_valid_reg;
    assign result.valid = main_valid_reg;
    assign result.data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            if (!main_valid_next)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

@@ hw/rtl/usart_byte_level_model.sv @@
// usart_byte_level_model: top level of the byte-level usart model
// depends on ubl_pkg, ubl_in_if, ubl_out_if, ubl_core, ubl_out_buf
//
//  port       dir   handshake          word
//  item       in    valid / ready      ubl_item_t: bus access, rx byte, clock or dsr event
//  result     out   valid / ready      ubl_result_t: read data, sent byte, pin levels
//  cfg        in    cfg_we, no ready   cfg_wdata: external clock wired
//
// one word per cycle unless stalled; its result is registered in the output or skid entry
// the usart state updates in the accepting cycle, so consecutive words chain without gaps
// item.ready drops only while both result entries (output register and skid) are full
// rst_n is asynchronous and clears the usart state and buffer valid flags to power-on values
module usart_byte_level_model (
    input  logic      clk,
    input  logic      rst_n,
    ubl_in_if.sink    item,
    ubl_out_if.source result,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);
    import ubl_pkg::*;

    logic        accept;
    logic        can_push;
    ubl_result_t core_result;

    assign item.ready = can_push;
    assign accept     = item.valid & can_push;

    ubl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item.data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (core_result)
    );

    ubl_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .can_push  (can_push),
        .result    (result)
    );

endmodule

@@ hw/rtl/ubl_checker.sv @@
// ubl_checker: port-level checks on the usart model, bound to the top level
// depends on ubl_pkg and the usart_byte_level_model ports
module ubl_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input ubl_pkg::ubl_result_t result_data
);

    // after an accepted word a result is always on show the next cycle
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> result_valid)
        else $error("accepted word left no result");

    // back-pressure on the input only when a result is already waiting
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("input stalled with empty output");

    // a sent character empties the holding buffer
    a_sent_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.tx_valid |-> result_data.txe_pin)
        else $error("character sent but buffer not empty");

    // transmitter ready implies buffer empty
    a_txrdy_txe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.txrdy_pin |-> result_data.txe_pin)
        else $error("txrdy without txe");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

endmodule

bind usart_byte_level_model ubl_checker u_ubl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for usart_byte_level_model, predicts every result word
// depends on ubl_pkg, ubl_in_if, ubl_out_if and the usart_byte_level_model top level
module testbench;
    import ubl_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic [7:0] ST_TXRDY   = 8'h01;
    localparam logic [7:0] ST_RXRDY   = 8'h02;
    localparam logic [7:0] ST_TXE     = 8'h04;
    localparam logic [7:0] ST_PARITY  = 8'h08;
    localparam logic [7:0] ST_OVERRUN = 8'h10;
    localparam logic [7:0] ST_FRAMING = 8'h20;
    localparam logic [7:0] ST_SYNDET  = 8'h40;
    localparam logic [7:0] ST_DSR     = 8'h80;

    localparam logic [7:0] C_TXEN  = 8'h1 << CMD_TX_ENABLE;
    localparam logic [7:0] C_DTR   = 8'h1 << CMD_DTR;
    localparam logic [7:0] C_RXEN  = 8'h1 << CMD_RX_ENABLE;
    localparam logic [7:0] C_ERR   = 8'h1 << CMD_ERR_RESET;
    localparam logic [7:0] C_RTS   = 8'h1 << CMD_RTS;
    localparam logic [7:0] C_RESET = 8'h1 << CMD_INT_RESET;
    localparam logic [7:0] C_HUNT  = 8'h1 << CMD_HUNT;

    localparam int PIN_DTR = 0;
    localparam int PIN_RTS = 1;
    localparam int PIN_SYN = 2;

    localparam int CYCLE_LIMIT = 500000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ubl_in_if  item_ch ();
    ubl_out_if result_ch ();

    usart_byte_level_model dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // usart state as predicted
    phase_t      ctl_phase;
    logic [1:0]  syncs_due;
    logic [7:0]  sync_char [2];
    bit          is_sync;
    bit          one_sync;
    int unsigned char_len;
    logic [7:0]  stat;
    logic [7:0]  tx_buf;
    logic [7:0]  rx_buf;
    bit          tx_loaded;
    bit          rx_loaded;
    bit          tx_en;
    bit          rx_en;
    bit          hunt_on;
    bit          first_sync;
    bit          ext_clk;
    int unsigned shift_cnt;
    logic [2:0]  pins;
    logic        dsr_n_now;
    bit          sent_now;
    logic [7:0]  sent_val;

    ubl_result_t pending [$];

    int  fails;
    int  cycle_count;
    int  words_done;
    int  chars_out;
    int  sync_hits;
    int  status_reads;
    bit  in_driven;
    int  send_calm;
    int  ready_hold;
    int  ready_calm;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void refresh_status();
        stat &= ~(ST_DSR | ST_TXE | ST_RXRDY | ST_TXRDY);
        if (tx_en && !tx_loaded)
            stat |= ST_TXRDY;
        if (!tx_loaded)
            stat |= ST_TXE;
        if (rx_loaded)
            stat |= ST_RXRDY;
        if (dsr_n_now == 1'b0)
            stat |= ST_DSR;
    endfunction

    function automatic void internal_reset();
        ctl_phase   = PH_MODE;
        syncs_due   = 2'd0;
        sync_char[0] = 8'h00;
        sync_char[1] = 8'h00;
        is_sync     = 1'b0;
        one_sync    = 1'b0;
        char_len    = 1;
        stat        = ST_TXE;
        tx_buf      = 8'h00;
        rx_buf      = 8'h00;
        tx_loaded   = 1'b0;
        rx_loaded   = 1'b0;
        tx_en       = 1'b0;
        rx_en       = 1'b0;
        hunt_on     = 1'b0;
        first_sync  = 1'b0;
        shift_cnt   = 0;
        pins        = 3'b000;
    endfunction

    function automatic void finish_char();
        sent_now  = 1'b1;
        sent_val  = tx_buf;
        tx_loaded = 1'b0;
        refresh_status();
        chars_out++;
    endfunction

    function automatic void clock_transmitter(input int unsigned n);
        if (tx_en && tx_loaded)
        begin
            shift_cnt += n;
            if (shift_cnt > SHIFT_MAX)
                shift_cnt = int'(SHIFT_MAX);
            if (shift_cnt >= char_len)
            begin
                shift_cnt -= char_len;
                finish_char();
            end
        end
    endfunction

    function automatic void sync_hit();
        hunt_on    = 1'b0;
        first_sync = 1'b0;
        stat      |= ST_SYNDET;
        pins[PIN_SYN] = 1'b1;
        sync_hits++;
    endfunction

    function automatic ubl_result_t predict(input ubl_item_t w);
        ubl_result_t r;
        logic [7:0]  rd;
        logic [7:0]  v;
        int          bits;
        int          idx;
        rd        = 8'h00;
        dsr_n_now = w.dsr_n;
        sent_now  = 1'b0;
        sent_val  = 8'h00;
        case (w.operation)
            OP_BUS_READ:
            begin
                if (!w.address_bit)
                begin
                    rx_loaded = 1'b0;
                    refresh_status();
                    rd = rx_buf;
                end
                else
                begin
                    refresh_status();
                    rd = stat;
                    stat &= ~ST_SYNDET;
                    pins[PIN_SYN] = 1'b0;
                    status_reads++;
                end
            end
            OP_BUS_WRITE:
            begin
                v = w.write_data;
                if (!w.address_bit)
                begin
                    tx_buf    = v;
                    tx_loaded = 1'b1;
                    refresh_status();
                end
                else if (ctl_phase == PH_MODE)
                begin
                    bits = 5 + int'(v[3:2]) + int'(v[4]);
                    if (v[1:0] == BAUD_SYNC)
                    begin
                        is_sync     = 1'b1;
                        one_sync    = v[7];
                        char_len    = bits;
                        syncs_due   = one_sync ? 2'd1 : 2'd2;
                        ctl_phase   = PH_SYNC;
                    end
                    else
                    begin
                        is_sync = 1'b0;
                        bits += 1 + ((v[7:6] == STOP_TWO) ? 2 : 1);
                        if (v[1:0] == BAUD_X16)
                            bits *= 16;
                        else if (v[1:0] == BAUD_X64)
                            bits *= 64;
                        char_len  = bits;
                        ctl_phase = PH_CMD;
                    end
                end
                else if (ctl_phase == PH_SYNC)
                begin
                    idx = ((one_sync ? 1 : 2) - int'(syncs_due)) & 1;
                    sync_char[idx] = v;
                    syncs_due = syncs_due - 2'd1;
                    if (syncs_due == 2'd0)
                        ctl_phase = PH_CMD;
                end
                else if (v[CMD_INT_RESET])
                begin
                    internal_reset();
                end
                else
                begin
                    tx_en = v[CMD_TX_ENABLE];
                    rx_en = v[CMD_RX_ENABLE];
                    pins[PIN_DTR] = v[CMD_DTR];
                    pins[PIN_RTS] = v[CMD_RTS];
                    if (v[CMD_ERR_RESET])
                        stat &= ~(ST_FRAMING | ST_OVERRUN | ST_PARITY);
                    if (v[CMD_HUNT] && is_sync)
                    begin
                        hunt_on    = 1'b1;
                        first_sync = 1'b0;
                        stat      &= ~ST_SYNDET;
                        pins[PIN_SYN] = 1'b0;
                    end
                    refresh_status();
                end
            end
            OP_RX_BYTE:
            begin
                v = w.rx_byte;
                if (rx_en && is_sync && hunt_on)
                begin
                    if (v == sync_char[0])
                    begin
                        if (one_sync || first_sync)
                            sync_hit();
                        else
                            first_sync = 1'b1;
                    end
                    else if (!one_sync && first_sync && v == sync_char[1])
                        sync_hit();
                    else
                        first_sync = 1'b0;
                end
                else if (rx_en)
                begin
                    if (rx_loaded)
                        stat |= ST_OVERRUN;
                    rx_buf    = v;
                    rx_loaded = 1'b1;
                    refresh_status();
                end
            end
            OP_SYS_TICK:
            begin
                if (!ext_clk)
                    clock_transmitter(int'(w.tick_count));
            end
            OP_TXC_RISE:
            begin
                if (tx_en && tx_loaded)
                begin
                    shift_cnt++;
                    if (shift_cnt >= char_len)
                    begin
                        shift_cnt = 0;
                        finish_char();
                    end
                end
            end
            OP_C_RISE:
            begin
                ext_clk = 1'b1;
                clock_transmitter(1);
            end
            OP_DSR:
            begin
                refresh_status();
            end
            default:
            begin
            end
        endcase
        r.read_data  = rd;
        r.tx_valid   = sent_now;
        r.tx_byte    = sent_now ? sent_val : 8'h00;
        r.txrdy_pin  = stat[0];
        r.rxrdy_pin  = stat[1];
        r.txe_pin    = stat[2];
        r.dtr_pin    = pins[PIN_DTR];
        r.rts_pin    = pins[PIN_RTS];
        r.syndet_pin = pins[PIN_SYN];
        return r;
    endfunction

    function automatic ubl_item_t word_of(input logic [2:0] op, input logic a0,
                                          input logic [7:0] val);
        ubl_item_t w;
        w.operation   = op;
        w.address_bit = (op == OP_BUS_READ || op == OP_BUS_WRITE) ? a0 : 1'($urandom);
        w.write_data  = 8'($urandom);
        w.rx_byte     = 8'($urandom);
        w.tick_count  = 8'($urandom);
        w.dsr_n       = 1'($urandom);
        case (op)
            OP_BUS_WRITE: w.write_data = val;
            OP_RX_BYTE:   w.rx_byte    = val;
            OP_SYS_TICK:  w.tick_count = val;
            OP_DSR:       w.dsr_n      = val[0];
            default:
            begin
            end
        endcase
        return w;
    endfunction

    function automatic int stall_len();
        if ($urandom_range(9) < 8)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic int gap_len();
        if (send_calm > 0)
        begin
            send_calm--;
            return 0;
        end
        if ($urandom_range(99) < 3)
            send_calm = $urandom_range(80, 30);
        if ($urandom_range(99) < 35)
            return stall_len();
        return 0;
    endfunction

    // mostly well-formed traffic for whichever control phase the usart is in
    function automatic ubl_item_t next_random_word(input bit with_edges);
        int         pick;
        logic [7:0] v;
        pick = $urandom_range(99);
        v    = 8'($urandom);
        if (ctl_phase == PH_MODE && pick < 85)
        begin
            if ($urandom_range(9) < 4)
                v[1:0] = BAUD_SYNC;
            return word_of(OP_BUS_WRITE, 1'b1, v);
        end
        if (ctl_phase == PH_SYNC && pick < 85)
            return word_of(OP_BUS_WRITE, 1'b1, v);
        if (pick < 12)
        begin
            v[CMD_INT_RESET] = ($urandom_range(99) < 20);
            if ($urandom_range(9) < 8)
                v[CMD_TX_ENABLE] = 1'b1;
            if ($urandom_range(9) < 8)
                v[CMD_RX_ENABLE] = 1'b1;
            return word_of(OP_BUS_WRITE, 1'b1, v);
        end
        if (pick < 30)
            return word_of(OP_BUS_WRITE, 1'b0, v);
        if (pick < 45)
            return word_of(OP_BUS_READ, 1'($urandom), v);
        if (pick < 63)
        begin
            if (hunt_on && $urandom_range(9) < 7)
                v = sync_char[$urandom_range(1)];
            return word_of(OP_RX_BYTE, 1'b0, v);
        end
        if (pick < 80)
        begin
            if ($urandom_range(3) == 0)
                v = 8'hFF;
            return word_of(OP_SYS_TICK, 1'b0, v);
        end
        if (pick < 88)
            return word_of(OP_TXC_RISE, 1'b0, v);
        if (pick < 92 && with_edges)
            return word_of(OP_C_RISE, 1'b0, v);
        if (pick < 98)
            return word_of(OP_DSR, 1'b0, v);
        return word_of(OP_UNUSED, 1'b0, v);
    endfunction

    task automatic send_word(input ubl_item_t w);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            if (in_driven)
                item_ch.valid <= 1'b0;
            in_driven = 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= w;
        in_driven = 1'b1;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        pending.insert(pending.size(), predict(w));
        words_done++;
    endtask

    task automatic go_idle();
        if (in_driven)
            item_ch.valid <= 1'b0;
        in_driven = 1'b0;
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        while (pending.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        if (pending.size() != 0)
        begin
            $error("%0d result words never arrived", pending.size());
            fails++;
            pending.delete();
        end
    endtask

    task automatic write_wired(input logic v);
        go_idle();
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (v)
            ext_clk = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        ubl_result_t want;
        ubl_result_t got;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got = result_ch.data;
            if (pending.size() == 0)
            begin
                $error("result word with nothing pending");
                fails++;
            end
            else
            begin
                want = pending.pop_front();
                check_field("read_data", want.read_data, got.read_data);
                check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
                check_field("tx_byte", want.tx_byte, got.tx_byte);
                check_field("txrdy_pin", 8'(want.txrdy_pin), 8'(got.txrdy_pin));
                check_field("rxrdy_pin", 8'(want.rxrdy_pin), 8'(got.rxrdy_pin));
                check_field("txe_pin", 8'(want.txe_pin), 8'(got.txe_pin));
                check_field("dtr_pin", 8'(want.dtr_pin), 8'(got.dtr_pin));
                check_field("rts_pin", 8'(want.rts_pin), 8'(got.rts_pin));
                check_field("syndet_pin", 8'(want.syndet_pin), 8'(got.syndet_pin));
            end
        end
    end

    // receiver back-pressure: short stalls, the odd long one, quiet stretches
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            if (ready_calm > 0)
                ready_calm--;
            else if ($urandom_range(99) < 3)
                ready_calm = $urandom_range(200, 40);
            else if ($urandom_range(99) < 30)
                ready_hold = stall_len();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_idle_and_status();
        write_wired(1'b0);
        send_word(word_of(OP_BUS_READ, 1'b1, 8'h00));
        send_word(word_of(OP_BUS_READ, 1'b0, 8'h00));
        send_word(word_of(OP_UNUSED, 1'b0, 8'h00));
        send_word(word_of(OP_DSR, 1'b0, 8'h00));
        send_word(word_of(OP_BUS_WRITE, 1'b0, 8'h5A));
    endtask

    task automatic test_async_transmit();
        // x1 clock, 8 data bits, 1.5 stop bits counted as one
        send_word(word_of(OP_BUS_WRITE, 1'b1, 8'h8D));
        send_word(word_of(OP_BUS_WRITE, 1'b1, C_TXEN | C_DTR | C_RXEN | C_ERR | C_RTS));
        send_word(word_of(OP_SYS_TICK, 1'b0, 8'hFF));
        send_word(word_of(OP_BUS_WRITE, 1'b0, 8'hA5));
        send_word(word_of(OP_TXC_RISE, 1'b0, 8'h00));
        send_word(word_of(OP_BUS_WRITE, 1'b0, 8'hFF));
        send_word(word_of(OP_SYS_TICK, 1'b0, 8'h00));
        send_word(word_of(OP_SYS_TICK, 1'b0, 8'h09));
        send_word(word_of(OP_SYS_TICK, 1'b0, 8'h01));
    endtask

    task automatic test_receive_overrun();
        send_word(word_of(OP_RX_BYTE, 1'b0, 8'h3C));
        send_word(word_of(OP_RX_BYTE, 1'b0, 8'hC3));
        send_word(word_of(OP_BUS_READ, 1'b1, 8'h00));
        send_word(word_of(OP_BUS_READ, 1'b0, 8'h00));
        // hunt has no effect in async mode
        send_word(word_of(OP_BUS_WRITE, 1'b1, C_ERR | C_TXEN | C_RXEN | C_HUNT));
        send_word(word_of(OP_BUS_WRITE, 1'b1, C_RESET));
    endtask

    task automatic test_sync_hunt();
        send_word(word_of(OP_BUS_WRITE, 1'b1, 8'h1C));
        send_word(word_of(OP_BUS_WRITE, 1'b1, 8'h16));
        send_word(word_of(OP_BUS_WRITE, 1'b1, 8'h61));
        send_word(word_of(OP_BUS_WRITE, 1'b1, C_HUNT | C_RXEN));
        send_word(word_of(OP_RX_BYTE, 1'b0, 8'h16));
        send_word(word_of(OP_RX_BYTE, 1'b0, 8'h00));
        send_word(word_of(OP_RX_BYTE, 1'b0, 8'h16));
        send_word(word_of(OP_RX_BYTE, 1'b0, 8'h61));
        send_word(word_of(OP_BUS_READ, 1'b1, 8'h00));
        send_word(word_of(OP_RX_BYTE, 1'b0, 8'h77));
        send_word(word_of(OP_BUS_WRITE, 1'b1, C_RESET));
        // single sync character
        send_word(word_of(OP_BUS_WRITE, 1'b1, 8'h80));
        send_word(word_of(OP_BUS_WRITE, 1'b1, 8'hFF));
        send_word(word_of(OP_BUS_WRITE, 1'b1, C_HUNT | C_RXEN | C_TXEN));
        send_word(word_of(OP_RX_BYTE, 1'b0, 8'hFF));
    endtask

    task automatic run_random(input int count, input bit with_edges);
        repeat (count) send_word(next_random_word(with_edges));
    endtask

    // system ticks only count until the clock is marked external, so they go first
    task automatic test_random_system_clock();
        run_random(230, 1'b0);
    endtask

    task automatic test_external_clock_edges();
        run_random(100, 1'b1);
        write_wired(1'b1);
        run_random(90, 1'b1);
        write_wired(1'b0);
        run_random(80, 1'b1);
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        fails        = 0;
        cycle_count  = 0;
        words_done   = 0;
        chars_out    = 0;
        sync_hits    = 0;
        status_reads = 0;
        in_driven    = 1'b0;
        send_calm    = 0;
        ready_hold   = 0;
        ready_calm   = 0;
        ext_clk      = 1'b0;
        dsr_n_now    = 1'b1;
        sent_now     = 1'b0;
        sent_val     = 8'h00;
        internal_reset();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_status();
        test_async_transmit();
        test_receive_overrun();
        test_sync_hunt();
        test_random_system_clock();
        test_external_clock_edges();

        go_idle();
        wait_drained();
        repeat (8) @(posedge clk);

        $display("%0d words checked: %0d characters sent, %0d sync detections, %0d status reads",
                 words_done, chars_out, sync_hits, status_reads);
        $display("clocking by system ticks, transmit clock and external clock, wired 0 and 1");
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
